>>> src/eucjp_pkg.sv
// ============================================================================
// eucjp_pkg
// Shared codes for the EUC-JP character validator: status, code sets,
// byte range limits and field widths.
// ============================================================================
`default_nettype none

package eucjp_pkg;

    // Field widths
    localparam int ByteW   = 8;
    localparam int StatusW = 2;
    localparam int LenW    = 2;
    localparam int SetW    = 3;

    // Character status codes
    localparam logic [StatusW-1:0] ST_VALID      = 2'd0;
    localparam logic [StatusW-1:0] ST_BAD_LEAD   = 2'd1;
    localparam logic [StatusW-1:0] ST_BAD_TRAIL  = 2'd2;
    localparam logic [StatusW-1:0] ST_INCOMPLETE = 2'd3;

    // Code sets (pending set uses the low two bits, zero meaning none pending)
    localparam logic [SetW-1:0] SET_ASCII   = 3'd0;
    localparam logic [SetW-1:0] SET_JIS0208 = 3'd1;
    localparam logic [SetW-1:0] SET_KANA    = 3'd2;
    localparam logic [SetW-1:0] SET_JIS0212 = 3'd3;
    localparam logic [SetW-1:0] SET_NONE    = 3'd4;

    // Byte boundaries
    localparam logic [ByteW-1:0] ASCII_MAX  = 8'h7E;
    localparam logic [ByteW-1:0] MB_MIN     = 8'hA1;
    localparam logic [ByteW-1:0] MB_MAX     = 8'hFE;
    localparam logic [ByteW-1:0] SS2_LEAD   = 8'h8E;
    localparam logic [ByteW-1:0] KANA_MAX   = 8'hDF;
    localparam logic [ByteW-1:0] SS3_LEAD   = 8'h8F;

    // Character lengths
    localparam logic [LenW-1:0] LEN_ONE   = 2'd1;
    localparam logic [LenW-1:0] LEN_TWO   = 2'd2;
    localparam logic [LenW-1:0] LEN_THREE = 2'd3;

endpackage

`default_nettype wire

>>> src/eucjp_char_validator.sv
// ============================================================================
// eucjp_char_validator
// Splits a byte stream into EUC-JP characters and reports each finished one.
// ============================================================================
// Usage:
//   Input channel (s_valid/s_ready): one byte per item, with s_end_of_buffer
//   marking the last byte of a buffer. Result channel (m_valid/m_ready): one
//   item per finished character carrying status, length, code set and a
//   last-character flag. A multibyte lead byte gives no item unless it ends
//   the buffer. The result is registered and appears in the cycle after the
//   byte that finishes it is accepted. Throughput: one byte per cycle while
//   the result channel is not stalled, set by the single result register; a
//   new byte is taken in the same cycle the pending result leaves.
//   Reset (aresetn low, synchronous): clears the character in progress and
//   drops any result not yet taken.
//   Stall: while m_ready is low and a result is held, s_ready is low and the
//   result stays unchanged; bytes that finish no character still need the
//   result register free to be accepted.
//   After a byte flagged end of buffer, the character state clears and the next byte
//   is taken as a lead byte.
// ============================================================================
`default_nettype none

module eucjp_char_validator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [eucjp_pkg::ByteW-1:0]   s_data_byte,
    input  wire logic                          s_end_of_buffer,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [eucjp_pkg::StatusW-1:0]      m_char_status,
    output logic [eucjp_pkg::LenW-1:0]         m_char_length,
    output logic [eucjp_pkg::SetW-1:0]         m_code_set,
    output logic                               m_last_char
);

    // Character-in-progress state
    logic [1:0] pending_set_reg, pending_set_next;
    logic [1:0] bytes_taken_reg, bytes_taken_next;
    logic       trail_bad_reg,   trail_bad_next;

    // Result register
    logic                              out_valid_reg;
    logic [eucjp_pkg::StatusW-1:0]     out_status_reg, out_status_next;
    logic [eucjp_pkg::LenW-1:0]        out_length_reg, out_length_next;
    logic [eucjp_pkg::SetW-1:0]        out_set_reg,    out_set_next;
    logic                              out_last_reg,   out_last_next;
    logic                              emit;

    logic       accept;
    logic       trail_ok;
    logic [1:0] lead_set;
    logic [1:0] taken_inc;
    logic [1:0] need;

    // Take a byte whenever the result register is free or being emptied
    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Classify the byte as a lead: zero means ASCII or invalid lead
    always_comb begin
        priority if (s_data_byte >= eucjp_pkg::MB_MIN && s_data_byte <= eucjp_pkg::MB_MAX) begin
            lead_set = eucjp_pkg::SET_JIS0208[1:0];
        end else if (s_data_byte == eucjp_pkg::SS2_LEAD) begin
            lead_set = eucjp_pkg::SET_KANA[1:0];
        end else if (s_data_byte == eucjp_pkg::SS3_LEAD) begin
            lead_set = eucjp_pkg::SET_JIS0212[1:0];
        end else begin
            lead_set = 2'd0;
        end
    end

    // Check the byte as a trail of the pending set
    always_comb begin
        if (pending_set_reg == eucjp_pkg::SET_KANA[1:0]) begin
            trail_ok = s_data_byte >= eucjp_pkg::MB_MIN && s_data_byte <= eucjp_pkg::KANA_MAX;
        end else begin
            trail_ok = s_data_byte >= eucjp_pkg::MB_MIN && s_data_byte <= eucjp_pkg::MB_MAX;
        end
    end

    assign taken_inc = bytes_taken_reg + 2'd1;
    assign need      = (pending_set_reg == eucjp_pkg::SET_JIS0212[1:0])
                       ? eucjp_pkg::LEN_THREE : eucjp_pkg::LEN_TWO;

    // Advance the character state and form the result for one byte
    always_comb begin
        pending_set_next = pending_set_reg;
        bytes_taken_next = bytes_taken_reg;
        trail_bad_next   = trail_bad_reg;
        emit             = 1'b0;
        out_status_next  = eucjp_pkg::ST_VALID;
        out_length_next  = eucjp_pkg::LEN_ONE;
        out_set_next     = eucjp_pkg::SET_ASCII;
        out_last_next    = s_end_of_buffer;

        if (pending_set_reg == 2'd0) begin
            priority if (s_data_byte <= eucjp_pkg::ASCII_MAX) begin
                emit = 1'b1;
            end else if (lead_set == 2'd0) begin
                emit            = 1'b1;
                out_status_next = eucjp_pkg::ST_BAD_LEAD;
                out_set_next    = eucjp_pkg::SET_NONE;
            end else if (s_end_of_buffer) begin
                emit            = 1'b1;
                out_status_next = eucjp_pkg::ST_INCOMPLETE;
                out_set_next    = {1'b0, lead_set};
            end else begin
                pending_set_next = lead_set;
                bytes_taken_next = 2'd1;
                trail_bad_next   = 1'b0;
            end
        end else begin
            out_set_next = {1'b0, pending_set_reg};
            priority if (taken_inc >= need) begin
                emit            = 1'b1;
                out_status_next = (trail_bad_reg || !trail_ok)
                                  ? eucjp_pkg::ST_BAD_TRAIL : eucjp_pkg::ST_VALID;
                out_length_next = need;
                pending_set_next = 2'd0;
                bytes_taken_next = 2'd0;
                trail_bad_next   = 1'b0;
            end else if (s_end_of_buffer) begin
                emit            = 1'b1;
                out_status_next = eucjp_pkg::ST_INCOMPLETE;
                out_length_next = taken_inc;
                pending_set_next = 2'd0;
                bytes_taken_next = 2'd0;
                trail_bad_next   = 1'b0;
            end else begin
                bytes_taken_next = taken_inc;
                trail_bad_next   = trail_bad_reg || !trail_ok;
            end
        end
    end

    // Hold character state; clear it at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_set_reg <= 2'd0;
            bytes_taken_reg <= 2'd0;
            trail_bad_reg   <= 1'b0;
        end else if (accept) begin
            pending_set_reg <= pending_set_next;
            bytes_taken_reg <= bytes_taken_next;
            trail_bad_reg   <= trail_bad_next;
        end
    end

    // Result valid flag: load on an emitting byte, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            out_status_reg <= out_status_next;
            out_length_reg <= out_length_next;
            out_set_reg    <= out_set_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_char_status = out_status_reg;
    assign m_char_length = out_length_reg;
    assign m_code_set    = out_set_reg;
    assign m_last_char   = out_last_reg;

endmodule

`default_nettype wire

>>> src/eucjp_checker.sv
// ============================================================================
// eucjp_checker
// Port-level checks on the result channel of the EUC-JP validator.
// ============================================================================
`default_nettype none

module eucjp_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [eucjp_pkg::StatusW-1:0] m_char_status,
    input wire logic [eucjp_pkg::LenW-1:0]    m_char_length,
    input wire logic [eucjp_pkg::SetW-1:0]    m_code_set,
    input wire logic                          m_last_char
);

    // Hold a stalled result unchanged
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_char_status)
            && $stable(m_char_length) && $stable(m_code_set) && $stable(m_last_char))
        else $error("stalled result changed");

    // A bad lead byte is one byte with no code set
    a_bad_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_char_status == eucjp_pkg::ST_BAD_LEAD |->
            m_char_length == eucjp_pkg::LEN_ONE && m_code_set == eucjp_pkg::SET_NONE)
        else $error("bad lead result malformed");

    // An incomplete character always ends the buffer
    a_incomplete: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_char_status == eucjp_pkg::ST_INCOMPLETE |->
            m_last_char && m_code_set != eucjp_pkg::SET_ASCII
            && m_code_set != eucjp_pkg::SET_NONE)
        else $error("incomplete result malformed");

    // ASCII is always a valid single byte
    a_ascii: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_code_set == eucjp_pkg::SET_ASCII |->
            m_char_status == eucjp_pkg::ST_VALID && m_char_length == eucjp_pkg::LEN_ONE)
        else $error("ascii result malformed");

    // Three-byte length only for the supplementary set
    a_len3: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_char_length == eucjp_pkg::LEN_THREE |->
            m_code_set == eucjp_pkg::SET_JIS0212)
        else $error("three-byte length with wrong code set");

endmodule

bind eucjp_char_validator eucjp_checker u_eucjp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_char_status (m_char_status),
    .m_char_length (m_char_length),
    .m_code_set    (m_code_set),
    .m_last_char   (m_last_char)
);

`default_nettype wire
